// ----- hdl/ssm_pkg.sv -----
// shared types and constants for the substring first-match search
package ssm_pkg;

  // pattern storage is fixed by the register map
  localparam int PATTERN_BYTES = 16;
  localparam int LEN_BITS      = 5;
  localparam int START_BITS    = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LEN  = 2'd2;

  // per-byte classification passed from front to back
  typedef struct packed {
    logic hit;
    logic last;
  } ssm_flags_t;

  typedef logic [7:0] byte_t;

endpackage

// ----- hdl/substring_first_match.sv -----
// top level of the streaming first-match substring search
// usage:
//   text bytes enter through push/full, one request per byte, last_byte set
//   on the final byte of each text. one result per text leaves through
//   empty/pop: match_found and match_start of the first occurrence.
//   the pattern is loaded over the cfg channel (index 0 low bytes, 1 high
//   bytes, 2 length); cfg_ready is always high, writes only while idle.
// throughput: one byte per cycle while full is low, set by the combinational window
//   compare in the front end; the result queue decouples a stalled receiver.
// result path: the last byte of a text is registered in the front-to-back
//   queue, then its result is registered in the result queue, whose head
//   drives match_found and match_start.
// stalls: when the receiver holds off pop, the result queue fills, the
//   back end stops on the next last byte and the middle queue then fills,
//   raising full; no request is ever dropped.
// reset: clears the queues, position count and hit state; the pattern
//   registers return to zero (empty pattern, which matches at position 0).
module substring_first_match
  import ssm_pkg::*;
#(
  parameter int MAX_PATTERN   = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  // byte requests
  input  logic                     push,
  output logic                     full,
  input  logic [7:0]               text_byte,
  input  logic                     last_byte,
  // results
  output logic                     empty,
  input  logic                     pop,
  output logic                     match_found,
  output logic [START_BITS-1:0]    match_start,
  // configuration writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  // the usable pattern length is capped by both the register map and the window
  localparam int WIN_BYTES = (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN : PATTERN_BYTES;
  localparam int MID_DEPTH = 4;
  localparam int MID_WIDTH = $bits(ssm_flags_t) + POSITION_BITS;

  logic [CFG_DATA_BITS-1:0] pattern_low_bytes;
  logic [CFG_DATA_BITS-1:0] pattern_high_bytes;
  logic [LEN_BITS-1:0]      pattern_length;
  logic [LEN_BITS-1:0]      len_act;
  logic                     accept;

  ssm_flags_t               front_flags;
  logic [POSITION_BITS-1:0] front_start;
  logic [MID_WIDTH-1:0]     mid_rdata;
  logic                     mid_empty;
  logic                     mid_pop;
  ssm_flags_t               back_flags;
  logic [POSITION_BITS-1:0] back_start;

  assign cfg_ready = 1'b1;

  // configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low_bytes  <= '0;
      pattern_high_bytes <= '0;
      pattern_length     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_LOW:  pattern_low_bytes  <= cfg_data;
        REG_PATTERN_HIGH: pattern_high_bytes <= cfg_data;
        REG_PATTERN_LEN:  pattern_length     <= cfg_data[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // overlong lengths fall back to the widest usable pattern
  assign len_act = (pattern_length > LEN_BITS'(WIN_BYTES)) ?
                   LEN_BITS'(WIN_BYTES) : pattern_length;

  assign accept = push && !full;

  ssm_front #(
    .WIN_BYTES     (WIN_BYTES),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .text_byte (text_byte),
    .last_byte (last_byte),
    .pattern   ({pattern_high_bytes, pattern_low_bytes}),
    .len       (len_act),
    .flags     (front_flags),
    .start     (front_start)
  );

  // short queue between the front and back ends
  ssm_queue #(
    .WIDTH (MID_WIDTH),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({front_flags, front_start}),
    .full  (full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  assign back_flags = mid_rdata[MID_WIDTH-1 -: $bits(ssm_flags_t)];
  assign back_start = mid_rdata[POSITION_BITS-1:0];

  ssm_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .mid_empty   (mid_empty),
    .flags       (back_flags),
    .start       (back_start),
    .mid_pop     (mid_pop),
    .len_zero    (len_act == '0),
    .empty       (empty),
    .pop         (pop),
    .match_found (match_found),
    .match_start (match_start)
  );

endmodule

// ----- hdl/ssm_queue.sv -----
// small first-in first-out queue built from registers
module ssm_queue
  import ssm_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    store [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == CNT_BITS'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/ssm_front.sv -----
// front end: byte window, position count and parallel pattern compare
module ssm_front
  import ssm_pkg::*;
#(
  parameter int WIN_BYTES = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  byte_t                    text_byte,
  input  logic                     last_byte,
  input  logic [8*PATTERN_BYTES-1:0] pattern,
  input  logic [LEN_BITS-1:0]      len,
  output ssm_flags_t               flags,
  output logic [POSITION_BITS-1:0] start
);

  localparam int CW = POSITION_BITS + LEN_BITS;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  byte_t                    window      [WIN_BYTES];
  byte_t                    window_next [WIN_BYTES];
  byte_t                    pat         [PATTERN_BYTES];
  logic [POSITION_BITS-1:0] pos;
  logic [POSITION_BITS-1:0] pos_next;
  logic [WIN_BYTES-1:0]     lane_ok;
  logic [CW-1:0]            pos_wide;
  logic [CW-1:0]            len_wide;
  logic [CW-1:0]            start_wide;

  always_comb begin
    for (int k = 0; k < PATTERN_BYTES; k++) begin
      pat[k] = pattern[8*k +: 8];
    end
  end

  always_comb begin
    window_next[0] = text_byte;
    for (int j = 1; j < WIN_BYTES; j++) begin
      window_next[j] = window[j-1];
    end
  end

  assign pos_next = (pos == POS_MAX) ? pos : pos + 1'b1;

  // lane j holds the byte j places back; it meets pattern byte len-1-j
  always_comb begin
    for (int j = 0; j < WIN_BYTES; j++) begin
      logic [LEN_BITS-1:0] pidx;
      pidx = len - LEN_BITS'(j) - 1'b1;
      lane_ok[j] = (LEN_BITS'(j) >= len) ||
                   (window_next[j] == pat[pidx[$clog2(PATTERN_BYTES)-1:0]]);
    end
  end

  assign pos_wide   = CW'(pos_next);
  assign len_wide   = CW'(len);
  assign start_wide = pos_wide - len_wide;

  assign flags.hit  = (len != '0) && (pos_wide >= len_wide) && (&lane_ok);
  assign flags.last = last_byte;
  assign start      = start_wide[POSITION_BITS-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= last_byte ? '0 : pos_next;
    end
  end

endmodule

// ----- hdl/ssm_back.sv -----
// back end: first-hit tracking per text and the result queue
module ssm_back
  import ssm_pkg::*;
#(
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     mid_empty,
  input  ssm_flags_t               flags,
  input  logic [POSITION_BITS-1:0] start,
  output logic                     mid_pop,
  input  logic                     len_zero,
  output logic                     empty,
  input  logic                     pop,
  output logic                     match_found,
  output logic [START_BITS-1:0]    match_start
);

  localparam int EW = POSITION_BITS + START_BITS;

  logic                     hit_seen;
  logic [POSITION_BITS-1:0] hit_start;
  logic                     out_full;
  logic                     res_push;
  logic                     res_found;
  logic [POSITION_BITS-1:0] res_pos;
  logic [EW-1:0]            res_wide;
  logic [START_BITS:0]      res_data;
  logic [START_BITS:0]      out_data;

  // a last byte waits until the result queue has room
  assign mid_pop  = !mid_empty && (!flags.last || !out_full);
  assign res_push = mid_pop && flags.last;

  always_comb begin
    res_found = len_zero || hit_seen || flags.hit;
    if (len_zero) begin
      res_pos = '0;
    end else if (hit_seen) begin
      res_pos = hit_start;
    end else if (flags.hit) begin
      res_pos = start;
    end else begin
      res_pos = '0;
    end
  end

  assign res_wide = EW'(res_pos);
  assign res_data = {res_found, res_wide[START_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_seen <= 1'b0;
    end else if (mid_pop) begin
      if (flags.last) begin
        hit_seen <= 1'b0;
      end else if (flags.hit) begin
        hit_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop && !hit_seen && flags.hit) begin
      hit_start <= start;
    end
  end

  ssm_queue #(
    .WIDTH (START_BITS + 1),
    .DEPTH (2)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_data),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_data),
    .empty (empty)
  );

  assign match_found = out_data[START_BITS];
  assign match_start = out_data[START_BITS-1:0];

endmodule
